/* hdl/lprs_pkg.sv */
package lprs_pkg;

    localparam int ADDR_W   = 32;
    localparam int LEN_W    = 6;
    localparam int METRIC_W = 32;
    localparam int INDEX_W  = 6;
    localparam int COUNT_W  = 7;

    // Request kinds carried in req_type.
    localparam logic REQ_WRITE  = 1'b0;
    localparam logic REQ_LOOKUP = 1'b1;

    // Prefix length of a host route, also the saturation limit.
    localparam logic [LEN_W-1:0] HOST_LEN = 6'd32;

    // One table entry as held in the route memory.
    typedef struct packed {
        logic [ADDR_W-1:0]   prefix;
        logic [LEN_W-1:0]    len;
        logic [METRIC_W-1:0] metric;
    } lprs_entry_t;

    localparam int ENTRY_W = $bits(lprs_entry_t);

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic start;
        logic wr_req;
        logic issue;
        logic eval_en;
        logic load_out;
    } lprs_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic host_hit;
    } lprs_stat_t;

endpackage

/* hdl/lprs_ifs.sv */
interface lprs_req_if
    import lprs_pkg::*;
();
    logic                valid;
    logic                ready;
    logic                req_type;
    logic [INDEX_W-1:0]  entry_index;
    logic [ADDR_W-1:0]   prefix_addr;
    logic [LEN_W-1:0]    prefix_len;
    logic [METRIC_W-1:0] route_metric;
    logic [ADDR_W-1:0]   lookup_addr;

    modport source (
        output valid, req_type, entry_index, prefix_addr, prefix_len, route_metric,
               lookup_addr,
        input  ready
    );
    modport sink (
        input  valid, req_type, entry_index, prefix_addr, prefix_len, route_metric,
               lookup_addr,
        output ready
    );
endinterface

interface lprs_rsp_if
    import lprs_pkg::*;
();
    logic                valid;
    logic                ready;
    logic                found;
    logic [INDEX_W-1:0]  best_index;
    logic [LEN_W-1:0]    best_len;
    logic [METRIC_W-1:0] best_metric;
    logic                host_route;

    modport source (
        output valid, found, best_index, best_len, best_metric, host_route,
        input  ready
    );
    modport sink (
        input  valid, found, best_index, best_len, best_metric, host_route,
        output ready
    );
endinterface

interface lprs_cfg_if
    import lprs_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [COUNT_W-1:0] data;

    modport source (
        output valid, data,
        input  ready
    );
    modport sink (
        input  valid, data,
        output ready
    );
endinterface

/* hdl/longest_prefix_route_select.sv */
// Channel  Direction  Carries
// -------  ---------  ---------------------------------------------------------
// req      sink       route write or lookup word (req_type selects which)
// rsp      source     one result word per request: found, slot, length, metric
// cfg      sink       route_count, number of slots scanned from slot 0
//
// A write, or a lookup with N = min(route_count, TABLE_DEPTH) at zero, goes
// straight to FINISH. A lookup scans one entry per cycle through the single
// read port, then DRAIN, then FINISH; a host route at slot j that becomes the
// selection ends the scan. The next request is taken back in IDLE.
// Reset clears the controller and route_count; the table is not cleared.
// A held result does not block the next request, which is taken and worked
// on; only its own result waits for the output register to empty.

module longest_prefix_route_select
    import lprs_pkg::*;
#(
    parameter int TABLE_DEPTH = 64
) (
    input  logic       clk,
    input  logic       rst_n,
    lprs_req_if.sink   req,
    lprs_rsp_if.source rsp,
    lprs_cfg_if.sink   cfg
);

    // Width of a slot address inside the route memory.
    localparam int IDX_W = $clog2(TABLE_DEPTH);

    lprs_cmd_t        cmd;
    lprs_stat_t       stat;
    logic [IDX_W-1:0] rd_addr;
    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr;
    lprs_entry_t      ram_wdata;
    lprs_entry_t      ram_rdata;
    logic [ENTRY_W-1:0] ram_rdata_bits;

    // The controller sequences writes, the scan and the output register.
    lprs_ctrl #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .IDX_W       (IDX_W)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_type  (req.req_type),
        .req_ready (req.ready),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .cfg_valid (cfg.valid),
        .cfg_data  (cfg.data),
        .cfg_ready (cfg.ready),
        .cmd       (cmd),
        .stat      (stat),
        .rd_addr   (rd_addr)
    );

    // The datapath matches each entry read back and keeps the best one.
    lprs_dp #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .IDX_W       (IDX_W)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .rd_addr      (rd_addr),
        .entry_index  (req.entry_index),
        .prefix_addr  (req.prefix_addr),
        .prefix_len   (req.prefix_len),
        .route_metric (req.route_metric),
        .lookup_addr  (req.lookup_addr),
        .ram_we       (ram_we),
        .ram_waddr    (ram_waddr),
        .ram_wdata    (ram_wdata),
        .ram_rdata    (ram_rdata),
        .found        (rsp.found),
        .best_index   (rsp.best_index),
        .best_len     (rsp.best_len),
        .best_metric  (rsp.best_metric),
        .host_route   (rsp.host_route)
    );

    // Route table: prefix, length and metric share one word per slot.
    lprs_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (cmd.issue),
        .raddr (rd_addr),
        .rdata (ram_rdata_bits)
    );

    assign ram_rdata = lprs_entry_t'(ram_rdata_bits);

endmodule

/* hdl/lprs_ram.sv */
module lprs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* hdl/lprs_ctrl.sv */
module lprs_ctrl
    import lprs_pkg::*;
#(
    parameter int TABLE_DEPTH = 64,
    parameter int IDX_W       = 6
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    input  logic             req_type,
    output logic             req_ready,
    output logic             rsp_valid,
    input  logic             rsp_ready,
    input  logic             cfg_valid,
    input  logic [COUNT_W-1:0] cfg_data,
    output logic             cfg_ready,
    output lprs_cmd_t        cmd,
    input  lprs_stat_t       stat,
    output logic [IDX_W-1:0] rd_addr
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_DRAIN  = 2'd2;
    localparam logic [1:0] ST_FINISH = 2'd3;

    logic [1:0]         state_reg, state_next;
    logic [COUNT_W-1:0] route_count_reg;
    logic [IDX_W-1:0]   cnt_reg, cnt_next;
    logic [IDX_W-1:0]   last_reg, last_next;
    logic               out_valid_reg, out_valid_next;
    logic               accept;
    logic [31:0]        count_ext;
    logic [31:0]        limit;

    assign req_ready = (state_reg == ST_IDLE);
    assign accept    = req_valid && req_ready;
    assign cfg_ready = 1'b1;
    assign rsp_valid = out_valid_reg;
    assign rd_addr   = cnt_reg;

    // Slots in use, clipped to the table size.
    assign count_ext = 32'(route_count_reg);
    assign limit     = (count_ext > 32'(TABLE_DEPTH)) ? 32'(TABLE_DEPTH) : count_ext;

    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        last_next    = last_reg;
        cmd          = '0;
        cmd.start    = accept;
        cmd.wr_req   = accept && (req_type == REQ_WRITE);
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if ((req_type == REQ_LOOKUP) && (limit != 32'd0))
                    begin
                        cnt_next   = '0;
                        last_next  = IDX_W'(limit - 32'd1);
                        state_next = ST_SCAN;
                    end
                    else
                    begin
                        state_next = ST_FINISH;
                    end
                end
            end
            ST_SCAN:
            begin
                cmd.issue   = 1'b1;
                cmd.eval_en = 1'b1;
                if (stat.host_hit)
                begin
                    state_next = ST_FINISH;
                end
                else if (cnt_reg == last_reg)
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_DRAIN:
            begin
                cmd.eval_en = 1'b1;
                state_next  = ST_FINISH;
            end
            ST_FINISH:
            begin
                cmd.load_out = !out_valid_reg || rsp_ready;
                if (cmd.load_out)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            route_count_reg <= '0;
            cnt_reg         <= '0;
            last_reg        <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            last_reg      <= last_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                route_count_reg <= cfg_data;
            end
        end
    end

endmodule

/* hdl/lprs_dp.sv */
module lprs_dp
    import lprs_pkg::*;
#(
    parameter int TABLE_DEPTH = 64,
    parameter int IDX_W       = 6
) (
    input  logic                clk,
    input  logic                rst_n,
    input  lprs_cmd_t           cmd,
    output lprs_stat_t          stat,
    input  logic [IDX_W-1:0]    rd_addr,
    input  logic [INDEX_W-1:0]  entry_index,
    input  logic [ADDR_W-1:0]   prefix_addr,
    input  logic [LEN_W-1:0]    prefix_len,
    input  logic [METRIC_W-1:0] route_metric,
    input  logic [ADDR_W-1:0]   lookup_addr,
    output logic                ram_we,
    output logic [IDX_W-1:0]    ram_waddr,
    output lprs_entry_t         ram_wdata,
    input  lprs_entry_t         ram_rdata,
    output logic                found,
    output logic [INDEX_W-1:0]  best_index,
    output logic [LEN_W-1:0]    best_len,
    output logic [METRIC_W-1:0] best_metric,
    output logic                host_route
);

    logic [31:0]         slot_ext;
    logic [ADDR_W-1:0]   lookup_reg;
    logic                eval_valid_reg;
    logic [IDX_W-1:0]    eval_idx_reg;
    logic                have_reg;
    logic [IDX_W-1:0]    best_idx_reg;
    logic [LEN_W-1:0]    best_len_reg;
    logic [METRIC_W-1:0] best_metric_reg;
    logic [ADDR_W-1:0]   mask;
    logic                match;
    logic                better;
    logic                update;
    logic [31:0]         best_idx_ext;

    // Route write: slots past the table are dropped, long prefixes saturate.
    assign slot_ext         = 32'(entry_index);
    assign ram_we           = cmd.wr_req && (slot_ext < 32'(TABLE_DEPTH));
    assign ram_waddr        = slot_ext[IDX_W-1:0];
    assign ram_wdata.prefix = prefix_addr;
    assign ram_wdata.len    = (prefix_len > HOST_LEN) ? HOST_LEN : prefix_len;
    assign ram_wdata.metric = route_metric;

    // Compare the entry read last cycle with the destination.
    assign mask   = ~({ADDR_W{1'b1}} >> ram_rdata.len);
    assign match  = ((lookup_reg ^ ram_rdata.prefix) & mask) == '0;
    assign better = !have_reg || (best_len_reg < ram_rdata.len)
                    || ((best_len_reg == ram_rdata.len) && (best_metric_reg > ram_rdata.metric));
    assign update = cmd.eval_en && eval_valid_reg && match && better;
    assign stat.host_hit = update && (ram_rdata.len == HOST_LEN);

    assign best_idx_ext = 32'(best_idx_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eval_valid_reg <= 1'b0;
            have_reg       <= 1'b0;
        end
        else
        begin
            eval_valid_reg <= cmd.issue;
            if (cmd.start)
            begin
                have_reg <= 1'b0;
            end
            else if (update)
            begin
                have_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            lookup_reg      <= lookup_addr;
            best_idx_reg    <= '0;
            best_len_reg    <= '0;
            best_metric_reg <= '0;
        end
        else if (update)
        begin
            best_idx_reg    <= eval_idx_reg;
            best_len_reg    <= ram_rdata.len;
            best_metric_reg <= ram_rdata.metric;
        end
        if (cmd.issue)
        begin
            eval_idx_reg <= rd_addr;
        end
        if (cmd.load_out)
        begin
            found       <= have_reg;
            best_index  <= best_idx_ext[INDEX_W-1:0];
            best_len    <= best_len_reg;
            best_metric <= best_metric_reg;
            host_route  <= have_reg && (best_len_reg == HOST_LEN);
        end
    end

endmodule

/* hdl/lprs_checker.sv */
module lprs_checker
    import lprs_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                req_valid,
    input logic                req_ready,
    input logic                rsp_valid,
    input logic                rsp_ready,
    input logic                found,
    input logic [INDEX_W-1:0]  best_index,
    input logic [LEN_W-1:0]    best_len,
    input logic [METRIC_W-1:0] best_metric,
    input logic                host_route
);

    // A word held on a stalled output keeps its contents.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(found) && $stable(best_index)
            && $stable(best_len) && $stable(best_metric) && $stable(host_route))
        else $error("result word changed while stalled");

    // Without a match every result field is zero.
    a_no_match_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !found |-> best_index == '0 && best_len == '0
            && best_metric == '0 && !host_route)
        else $error("result without a match carries nonzero fields");

    // The host-route flag follows the selected length.
    a_host_flag: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> host_route == (found && best_len == HOST_LEN))
        else $error("host_route disagrees with best_len");

    // One request is worked on at a time: no acceptance right after another.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request taken while the previous one is still in progress");

endmodule

bind longest_prefix_route_select lprs_checker u_lprs_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .req_valid   (req.valid),
    .req_ready   (req.ready),
    .rsp_valid   (rsp.valid),
    .rsp_ready   (rsp.ready),
    .found       (rsp.found),
    .best_index  (rsp.best_index),
    .best_len    (rsp.best_len),
    .best_metric (rsp.best_metric),
    .host_route  (rsp.host_route)
);

/* tb/lprs_route_checker.sv */
module lprs_route_checker
    import lprs_pkg::*;
#(
    parameter int TABLE_DEPTH = 64
) (
    input  logic clk,
    input  logic rst_n,
    lprs_req_if  req,
    lprs_rsp_if  rsp,
    lprs_cfg_if  cfg,
    output int   fail_count,
    output int   outstanding,
    output int   lookups_seen,
    output int   hits_seen,
    output int   host_hits_seen
);

    typedef struct packed {
        logic                found;
        logic [INDEX_W-1:0]  index;
        logic [LEN_W-1:0]    len;
        logic [METRIC_W-1:0] metric;
        logic                host;
    } route_result_t;

    // Shadow of the route table and of route_count, updated as words are taken.
    logic [COUNT_W-1:0]  route_count;
    logic [ADDR_W-1:0]   net_tbl    [TABLE_DEPTH];
    logic [LEN_W-1:0]    len_tbl    [TABLE_DEPTH];
    logic [METRIC_W-1:0] metric_tbl [TABLE_DEPTH];

    route_result_t pending_results [$];
    route_result_t want_word;
    route_result_t lookup_word;
    int            errors    = 0;
    int            lookups   = 0;
    int            hits      = 0;
    int            host_hits = 0;

    // Longest prefix wins, then the lower metric, then the earlier slot. The
    // first host route that becomes the selection ends the scan.
    function automatic route_result_t select_route(input logic [ADDR_W-1:0] dest);
        route_result_t     best;
        logic [ADDR_W-1:0] mask;
        int                scan_end;
        logic              done;
        best     = route_result_t'('0);
        done     = 1'b0;
        scan_end = (route_count > TABLE_DEPTH) ? TABLE_DEPTH : int'(route_count);
        for (int i = 0; i < scan_end && !done; i++)
        begin
            mask = (len_tbl[i] == '0) ? '0 : ~({ADDR_W{1'b1}} >> len_tbl[i]);
            if (((dest & mask) == (net_tbl[i] & mask)) &&
                (!best.found || best.len < len_tbl[i] ||
                 (best.len == len_tbl[i] && best.metric > metric_tbl[i])))
            begin
                best.found  = 1'b1;
                best.index  = INDEX_W'(i);
                best.len    = len_tbl[i];
                best.metric = metric_tbl[i];
                best.host   = (len_tbl[i] == HOST_LEN);
                done        = best.host;
            end
        end
        return best;
    endfunction

    task automatic compare_field(input string name, input logic [METRIC_W-1:0] want,
                                 input logic [METRIC_W-1:0] got);
        if (want !== got)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            route_count = '0;
            pending_results.delete();
        end
        else
        begin
            if (cfg.valid && cfg.ready)
                route_count = cfg.data;

            if (req.valid && req.ready)
            begin
                if (req.req_type == REQ_WRITE)
                begin
                    if (req.entry_index < TABLE_DEPTH)
                    begin
                        net_tbl[req.entry_index]    = req.prefix_addr;
                        len_tbl[req.entry_index]    = (req.prefix_len > HOST_LEN) ?
                                                      HOST_LEN : req.prefix_len;
                        metric_tbl[req.entry_index] = req.route_metric;
                    end
                    pending_results.push_back(route_result_t'('0));
                end
                else
                begin
                    lookup_word = select_route(req.lookup_addr);
                    lookups++;
                    if (lookup_word.found)
                        hits++;
                    if (lookup_word.host)
                        host_hits++;
                    pending_results.push_back(lookup_word);
                end
            end

            if (rsp.valid && rsp.ready)
            begin
                if (pending_results.size() == 0)
                begin
                    errors++;
                    $display("%0t: result word with no request waiting, found %b index %0d",
                             $time, rsp.found, rsp.best_index);
                end
                else
                begin
                    want_word = pending_results.pop_front();
                    compare_field("found", want_word.found, rsp.found);
                    compare_field("best_index", want_word.index, rsp.best_index);
                    compare_field("best_len", want_word.len, rsp.best_len);
                    compare_field("best_metric", want_word.metric, rsp.best_metric);
                    compare_field("host_route", want_word.host, rsp.host_route);
                end
            end
        end
        fail_count     <= errors;
        outstanding    <= pending_results.size();
        lookups_seen   <= lookups;
        hits_seen      <= hits;
        host_hits_seen <= host_hits;
    end

endmodule

/* tb/tb_longest_prefix_route_select.sv */
// Top of the route selector bench. This module makes stimulus: it writes
// route words and lookup words into the request channel, throttles the result
// channel, sets route_count between phases, runs a watchdog and gives the verdict.
// Result words are checked in lprs_route_checker, which watches the three channels.
module tb_longest_prefix_route_select
    import lprs_pkg::*;
();

    localparam int ROUTE_SLOTS   = 64;
    localparam int PHASE_WORDS   = 240;
    localparam int STALL_PCT     = 12;
    // Many times the longest legal quiet spell: a full lookup scan, or the
    // longest sender gap.
    localparam int QUIET_LIMIT   = 4000;
    localparam int SETTLE_CYCLES = ROUTE_SLOTS + 16;
    localparam int QUIET_PHASE   = 6;

    logic clk = 1'b0;
    logic rst_n;

    lprs_req_if route_req ();
    lprs_rsp_if route_rsp ();
    lprs_cfg_if route_cfg ();

    int fail_count;
    int outstanding;
    int lookups_seen;
    int hits_seen;
    int host_hits_seen;

    // When set, the result side takes every word without stalling.
    logic sink_steady;

    // Copy of what was written, used only to aim lookups at real routes.
    logic [ADDR_W-1:0]  net_seen [ROUTE_SLOTS];
    logic [LEN_W-1:0]   len_seen [ROUTE_SLOTS];
    logic [COUNT_W-1:0] active_count = '0;

    int words_sent    = 0;
    int settings_used = 0;
    int quiet_cycles  = 0;

    // route_count for each random phase; the last one is drawn at run time.
    int phase_count [8] = '{64, 1, 127, 0, 23, 65, 64, 0};

    always #1 clk = ~clk;

    longest_prefix_route_select #(
        .TABLE_DEPTH(ROUTE_SLOTS)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (route_req),
        .rsp   (route_rsp),
        .cfg   (route_cfg)
    );

    lprs_route_checker #(
        .TABLE_DEPTH(ROUTE_SLOTS)
    ) route_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .req            (route_req),
        .rsp            (route_rsp),
        .cfg            (route_cfg),
        .fail_count     (fail_count),
        .outstanding    (outstanding),
        .lookups_seen   (lookups_seen),
        .hits_seen      (hits_seen),
        .host_hits_seen (host_hits_seen)
    );

    // The result side drops ready in about 12 percent of cycles, except
    // during the steady phase.
    always @(posedge clk)
    begin
        route_rsp.ready <= sink_steady || ($urandom_range(0, 99) >= STALL_PCT);
    end

    // Watchdog: any accepted word on any channel restarts the count.
    always @(posedge clk)
    begin
        if (!rst_n || (route_req.valid && route_req.ready) ||
            (route_rsp.valid && route_rsp.ready) || (route_cfg.valid && route_cfg.ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles == QUIET_LIMIT)
        begin
            $display("%0t: no word accepted for %0d cycles", $time, QUIET_LIMIT);
            $display("tb_longest_prefix_route_select: FAIL");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Presents one request word and returns at the edge where it is taken.
    // Valid is left high so that a following word goes out back to back.
    task automatic send_word(input logic kind, input logic [INDEX_W-1:0] slot,
                             input logic [ADDR_W-1:0] net, input logic [LEN_W-1:0] len,
                             input logic [METRIC_W-1:0] metric,
                             input logic [ADDR_W-1:0] dest);
        route_req.valid        <= 1'b1;
        route_req.req_type     <= kind;
        route_req.entry_index  <= slot;
        route_req.prefix_addr  <= net;
        route_req.prefix_len   <= len;
        route_req.route_metric <= metric;
        route_req.lookup_addr  <= dest;
        @(posedge clk);
        while (!route_req.ready)
            @(posedge clk);
        words_sent++;
    endtask

    task automatic write_route(input logic [INDEX_W-1:0] slot, input logic [ADDR_W-1:0] net,
                               input logic [LEN_W-1:0] len,
                               input logic [METRIC_W-1:0] metric);
        net_seen[slot] = net;
        len_seen[slot] = (len > HOST_LEN) ? HOST_LEN : len;
        send_word(REQ_WRITE, slot, net, len, metric, $urandom);
    endtask

    // The write fields of a lookup word are don't-care, so they carry noise.
    task automatic lookup_route(input logic [ADDR_W-1:0] dest);
        send_word(REQ_LOOKUP, INDEX_W'($urandom), $urandom, LEN_W'($urandom), $urandom,
                  dest);
    endtask

    // Holds the request side off until every result word has come back.
    // The first edge lets the checker's count catch up with the last word.
    task automatic drain();
        route_req.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    // route_count is only ever changed with the block idle.
    task automatic set_route_count(input logic [COUNT_W-1:0] value);
        drain();
        route_cfg.data  <= value;
        route_cfg.valid <= 1'b1;
        @(posedge clk);
        while (!route_cfg.ready)
            @(posedge clk);
        route_cfg.valid <= 1'b0;
        active_count = value;
        settings_used++;
    endtask

    // One random word. Writes draw networks from a few crowded ranges so that
    // routes overlap, with short metrics so that ties are common. Most lookups
    // land inside a route that is in the scanned part of the table.
    task automatic random_word();
        int                  pick;
        int                  span;
        logic [INDEX_W-1:0]  slot;
        logic [ADDR_W-1:0]   net;
        logic [ADDR_W-1:0]   dest;
        logic [ADDR_W-1:0]   mask;
        logic [LEN_W-1:0]    len;
        logic [METRIC_W-1:0] metric;
        if ($urandom_range(0, 99) < 30)
        begin
            slot = INDEX_W'($urandom_range(0, ROUTE_SLOTS - 1));
            net  = $urandom;
            case ($urandom_range(0, 4))
                0:       net[31:16] = 16'h0A00;
                1:       net[31:16] = 16'hC0A8;
                2:       net[31:16] = 16'hAC10;
                3:       net[31:16] = 16'hFFFF;
                default: ;
            endcase
            if ($urandom_range(0, 1) == 1)
                net[15:8] = 8'h01;
            if ($urandom_range(0, 1) == 1)
                net[7:0] = 8'($urandom_range(0, 3));
            pick = $urandom_range(0, 99);
            if (pick < 5)
                len = '0;
            else if (pick < 15)
                len = LEN_W'($urandom_range(33, 63));
            else if (pick < 40)
                len = HOST_LEN;
            else
                len = LEN_W'($urandom_range(8, 31));
            metric = ($urandom_range(0, 99) < 60) ? $urandom_range(0, 3) : $urandom;
            write_route(slot, net, len, metric);
        end
        else
        begin
            span = (active_count > ROUTE_SLOTS) ? ROUTE_SLOTS : int'(active_count);
            dest = $urandom;
            if (span > 0 && $urandom_range(0, 99) < 75)
            begin
                slot = INDEX_W'($urandom_range(0, span - 1));
                mask = (len_seen[slot] == '0) ? '0 : ~({ADDR_W{1'b1}} >> len_seen[slot]);
                dest = (net_seen[slot] & mask) | (dest & ~mask);
            end
            lookup_route(dest);
        end
    endtask

    // A phase of random words. Halfway through, the sender waits until the
    // block has answered everything before it goes on.
    task automatic run_phase(input int words, input logic steady);
        int gap;
        sink_steady <= steady;
        for (int n = 0; n < words; n++)
        begin
            if (n == words / 2)
            begin
                drain();
            end
            else if (!steady && $urandom_range(0, 99) < STALL_PCT)
            begin
                // Mostly short gaps, now and then a longer one that can outlast a full scan.
                gap = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80) :
                                                    $urandom_range(1, 6);
                route_req.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            random_word();
        end
    endtask

    initial
    begin
        route_req.valid        <= 1'b0;
        route_req.req_type     <= REQ_WRITE;
        route_req.entry_index  <= '0;
        route_req.prefix_addr  <= '0;
        route_req.prefix_len   <= '0;
        route_req.route_metric <= '0;
        route_req.lookup_addr  <= '0;
        route_cfg.valid        <= 1'b0;
        route_cfg.data         <= '0;
        sink_steady            <= 1'b0;
        rst_n                  <= 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // With route_count at its reset value of zero nothing is scanned, so
        // every lookup misses, even at the extremes of the address.
        lookup_route(32'h0000_0000);
        lookup_route(32'hFFFF_FFFF);

        // A small table built to hit each selection rule in turn.
        write_route(6'd0, 32'h0000_0000, 6'd0, 32'hFFFF_FFFF);   // default route
        write_route(6'd1, 32'h0A00_0000, 6'd8, 32'd5);
        write_route(6'd2, 32'h0A01_0000, 6'd16, 32'd7);
        write_route(6'd3, 32'h0A01_0000, 6'd16, 32'd3);          // lower metric wins
        write_route(6'd4, 32'h0A01_0000, 6'd16, 32'd3);          // full tie, slot 3 stays
        write_route(6'd5, 32'h0A01_0203, HOST_LEN, 32'd9);       // host route ends scan
        write_route(6'd6, 32'h0A01_0203, HOST_LEN, 32'd1);       // never reached
        write_route(6'd7, 32'hC0A8_01FF, 6'd24, 32'd0);          // host bits in network
        write_route(6'd8, 32'hFFFF_FFFF, 6'd63, 32'd0);          // length saturates to 32
        write_route(6'd9, 32'hAAAA_AAAA, 6'd33, 32'h1234_5678);
        set_route_count(7'd10);

        lookup_route(32'h0A01_0203);
        lookup_route(32'h0A01_0909);
        lookup_route(32'h0A02_0000);
        lookup_route(32'h0B00_0000);
        lookup_route(32'hC0A8_014D);
        lookup_route(32'hFFFF_FFFF);
        lookup_route(32'hAAAA_AAAA);
        lookup_route(32'h0000_0000);

        // Fill the rest of the table so that any route_count, including those
        // past the table size, scans only slots that hold a route.
        for (int s = 10; s < ROUTE_SLOTS; s++)
            write_route(INDEX_W'(s), $urandom, LEN_W'($urandom_range(0, 32)), $urandom);

        phase_count[7] = $urandom_range(0, 127);
        for (int p = 0; p < 8; p++)
        begin
            set_route_count(COUNT_W'(phase_count[p]));
            run_phase(PHASE_WORDS, p == QUIET_PHASE);
        end

        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Sent %0d request words, %0d of them lookups (%0d matched, %0d on host routes),",
                 words_sent, lookups_seen, hits_seen, host_hits_seen);
        $display("across %0d route_count settings from 0 to 127 with stalls on both sides.",
                 settings_used);
        if (fail_count == 0)
            $display("tb_longest_prefix_route_select: PASS");
        else
            $display("tb_longest_prefix_route_select: FAIL");
        $finish;
    end

endmodule
